// ===== src/urlc_pkg.sv =====
// shared types, constants and helpers for the ultrasonic ranging led controller
package urlc_pkg;

  localparam int TICK_W = 20;
  localparam int DIST_W = 11;
  localparam int TRIG_W = 10;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  // echo ticks per centimeter, kept as quotient and remainder
  localparam int US_PER_CM = 58;
  localparam int REM_W = 6;
  localparam logic [REM_W-1:0] REM_LAST = REM_W'(US_PER_CM - 1);

  // reset values of the configuration registers
  localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS = TRIG_W'(10);
  localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS = TICK_W'(100000);
  localparam logic [DIST_W-1:0] RST_NEAR_CM       = DIST_W'(10);
  localparam logic [DIST_W-1:0] RST_FAR_CM        = DIST_W'(50);
  localparam logic [TICK_W-1:0] RST_FLASH_TICKS   = TICK_W'(500000);
  localparam logic [TICK_W-1:0] RST_GAP_TICKS     = TICK_W'(500000);

  // command bytes
  localparam logic [7:0] CMD_ON_UC    = 8'h49;  // I
  localparam logic [7:0] CMD_ON_LC    = 8'h69;  // i
  localparam logic [7:0] CMD_OFF_UC   = 8'h4F;  // O
  localparam logic [7:0] CMD_OFF_LC   = 8'h6F;  // o
  localparam logic [7:0] CMD_FLASH_UC = 8'h46;  // F
  localparam logic [7:0] CMD_FLASH_LC = 8'h66;  // f

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 3'd0,
    CFG_TIMEOUT_TICKS = 3'd1,
    CFG_NEAR_CM       = 3'd2,
    CFG_FAR_CM        = 3'd3,
    CFG_FLASH_TICKS   = 3'd4,
    CFG_GAP_TICKS     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_GAP  = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } led_mode_t;

  typedef struct packed {
    logic              trigger_level;
    logic              led_level;
    led_mode_t         led_mode_now;
    logic [DIST_W-1:0] range_cm;
    logic              distance_new;
    logic              timed_out;
  } res_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    sat_inc = (v == TICK_MAX) ? v : v + TICK_W'(1);
  endfunction

endpackage

// ===== src/ultrasonic_ranging_led_controller.sv =====
// top level of the ultrasonic ranging led controller
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | mode, echo_level, command_byte
//  out_    | output    | out_valid / out_ready | trigger, led, mode, range, flags
//  cfg_    | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// one transaction per clock in steady state while out_ready stays high; an accepted input
// goes from the input register to the result register, or to the skid entry on a stall
// all state advances when the input register hands its item to the result side
// a skid entry behind the result register holds one result while the output stalls;
// in_ready drops only while the skid entry and the input register are both full
// reset (rst_n low, synchronous): gap phase, zero counts, led flashing and on, default config
module ultrasonic_ranging_led_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic                               in_echo_level,
  input  logic [7:0]                         in_command_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_trigger_level,
  output logic                               out_led_level,
  output logic [1:0]                         out_led_mode_now,
  output logic [urlc_pkg::DIST_W-1:0]        out_range_cm,
  output logic                               out_distance_new,
  output logic                               out_timed_out,
  // configuration port
  input  logic                               cfg_we,
  input  logic [urlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urlc_pkg::CFG_W-1:0]         cfg_wdata
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [urlc_pkg::TRIG_W-1:0] trigger_ticks_r;
  logic [urlc_pkg::TICK_W-1:0] timeout_ticks_r;
  logic [urlc_pkg::DIST_W-1:0] near_cm_r;
  logic [urlc_pkg::DIST_W-1:0] far_cm_r;
  logic [urlc_pkg::TICK_W-1:0] flash_ticks_r;
  logic [urlc_pkg::TICK_W-1:0] gap_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= urlc_pkg::RST_TRIGGER_TICKS;
      timeout_ticks_r <= urlc_pkg::RST_TIMEOUT_TICKS;
      near_cm_r       <= urlc_pkg::RST_NEAR_CM;
      far_cm_r        <= urlc_pkg::RST_FAR_CM;
      flash_ticks_r   <= urlc_pkg::RST_FLASH_TICKS;
      gap_ticks_r     <= urlc_pkg::RST_GAP_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urlc_pkg::CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[urlc_pkg::TRIG_W-1:0];
        urlc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[urlc_pkg::TICK_W-1:0];
        urlc_pkg::CFG_NEAR_CM:       near_cm_r       <= cfg_wdata[urlc_pkg::DIST_W-1:0];
        urlc_pkg::CFG_FAR_CM:        far_cm_r        <= cfg_wdata[urlc_pkg::DIST_W-1:0];
        urlc_pkg::CFG_FLASH_TICKS:   flash_ticks_r   <= cfg_wdata[urlc_pkg::TICK_W-1:0];
        urlc_pkg::CFG_GAP_TICKS:     gap_ticks_r     <= cfg_wdata[urlc_pkg::TICK_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register, result register, skid entry
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic s1_mode_r, s1_echo_r;
  logic [7:0] s1_cmd_r;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  urlc_pkg::res_t out_r, skid_r, res;

  logic in_fire, s1_fire, out_pop;

  assign in_fire  = in_valid && in_ready;
  // the item in the input register moves on whenever the skid entry is free
  assign s1_fire  = s1_valid_r && !skid_valid_r;
  assign in_ready = !s1_valid_r || s1_fire;
  assign out_pop  = out_valid_r && out_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // result buffer occupancy: skid drains into the result register first
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (s1_fire) begin
      if (!out_valid_r || out_pop) begin
        out_valid_nxt = 1'b1;
      end else begin
        skid_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_echo_r <= in_echo_level;
      s1_cmd_r  <= in_command_byte;
    end
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (s1_fire) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // measurement and led state
  // ---------------------------------------------------------------------------
  urlc_pkg::phase_t            phase_r, phase_nxt;
  logic [urlc_pkg::TICK_W-1:0] cnt_r, cnt_nxt;
  // echo width held as quotient (saturating at the distance maximum) and
  // remainder modulo the ticks per centimeter, so no divider is needed
  logic [urlc_pkg::DIST_W-1:0] echo_q_r, echo_q_nxt;
  logic [urlc_pkg::REM_W-1:0]  echo_rem_r, echo_rem_nxt;
  urlc_pkg::led_mode_t         mode_r, mode_nxt;
  logic                        led_r, led_nxt;
  logic [urlc_pkg::TICK_W-1:0] flash_cnt_r, flash_cnt_nxt;
  logic [urlc_pkg::DIST_W-1:0] last_dist_r, last_dist_nxt;

  logic                        trig, fin, tmo, cmd_hit;
  logic [urlc_pkg::DIST_W-1:0] meas_cm;
  urlc_pkg::led_mode_t         sel_mode;
  logic [urlc_pkg::TICK_W-1:0] trig_lim;

  assign trig_lim = {{(urlc_pkg::TICK_W - urlc_pkg::TRIG_W){1'b0}}, trigger_ticks_r};

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    echo_q_nxt    = echo_q_r;
    echo_rem_nxt  = echo_rem_r;
    mode_nxt      = mode_r;
    led_nxt       = led_r;
    flash_cnt_nxt = flash_cnt_r;
    last_dist_nxt = last_dist_r;
    trig          = 1'b0;
    fin           = 1'b0;
    tmo           = 1'b0;
    meas_cm       = '0;
    cmd_hit       = 1'b0;
    sel_mode      = urlc_pkg::LED_OFF;

    if (!s1_mode_r) begin
      // tick: a gap or trigger phase that ends hands the same tick on to the next phase
      if (phase_nxt == urlc_pkg::PH_GAP) begin
        if (cnt_nxt < gap_ticks_r) begin
          cnt_nxt = urlc_pkg::sat_inc(cnt_nxt);
        end else begin
          phase_nxt = urlc_pkg::PH_TRIG;
          cnt_nxt   = '0;
        end
      end
      if (phase_nxt == urlc_pkg::PH_TRIG) begin
        if (cnt_nxt < trig_lim) begin
          trig    = 1'b1;
          cnt_nxt = urlc_pkg::sat_inc(cnt_nxt);
        end else begin
          phase_nxt = urlc_pkg::PH_RISE;
          cnt_nxt   = '0;
        end
      end
      if (phase_nxt == urlc_pkg::PH_RISE) begin
        if (s1_echo_r) begin
          phase_nxt    = urlc_pkg::PH_FALL;
          cnt_nxt      = '0;
          echo_q_nxt   = '0;
          echo_rem_nxt = urlc_pkg::REM_W'(1);
        end else if (cnt_nxt >= timeout_ticks_r) begin
          fin = 1'b1;
          tmo = 1'b1;
        end else begin
          cnt_nxt = urlc_pkg::sat_inc(cnt_nxt);
        end
      end else if (phase_nxt == urlc_pkg::PH_FALL) begin
        if (!s1_echo_r) begin
          meas_cm = echo_q_r;
          fin     = 1'b1;
        end else if (cnt_nxt >= timeout_ticks_r) begin
          fin = 1'b1;
          tmo = 1'b1;
        end else begin
          cnt_nxt = urlc_pkg::sat_inc(cnt_nxt);
          if (echo_rem_r == urlc_pkg::REM_LAST) begin
            echo_rem_nxt = '0;
            if (echo_q_r != urlc_pkg::DIST_MAX) begin
              echo_q_nxt = echo_q_r + urlc_pkg::DIST_W'(1);
            end
          end else begin
            echo_rem_nxt = echo_rem_r + urlc_pkg::REM_W'(1);
          end
        end
      end

      if (fin) begin
        last_dist_nxt = meas_cm;
        phase_nxt     = urlc_pkg::PH_GAP;
        cnt_nxt       = '0;
        cmd_hit       = 1'b1;
        if (meas_cm < near_cm_r) begin
          sel_mode = urlc_pkg::LED_ON;
        end else if (meas_cm < far_cm_r) begin
          sel_mode = urlc_pkg::LED_FLASH;
        end else begin
          sel_mode = urlc_pkg::LED_OFF;
        end
      end
    end else begin
      // command byte: phase machine holds
      trig = (phase_r == urlc_pkg::PH_TRIG);
      priority if (s1_cmd_r == urlc_pkg::CMD_ON_UC || s1_cmd_r == urlc_pkg::CMD_ON_LC) begin
        cmd_hit  = 1'b1;
        sel_mode = urlc_pkg::LED_ON;
      end else if (s1_cmd_r == urlc_pkg::CMD_OFF_UC || s1_cmd_r == urlc_pkg::CMD_OFF_LC) begin
        cmd_hit  = 1'b1;
        sel_mode = urlc_pkg::LED_OFF;
      end else if (s1_cmd_r == urlc_pkg::CMD_FLASH_UC
                   || s1_cmd_r == urlc_pkg::CMD_FLASH_LC) begin
        cmd_hit  = 1'b1;
        sel_mode = urlc_pkg::LED_FLASH;
      end else begin
        cmd_hit  = 1'b0;  // unknown byte ignored
      end
    end

    // mode change; entering flashing restarts the flash counter
    if (cmd_hit) begin
      if (sel_mode == urlc_pkg::LED_FLASH && mode_r != urlc_pkg::LED_FLASH) begin
        flash_cnt_nxt = '0;
      end
      mode_nxt = sel_mode;
      if (sel_mode == urlc_pkg::LED_ON) begin
        led_nxt = 1'b1;
      end else if (sel_mode == urlc_pkg::LED_OFF) begin
        led_nxt = 1'b0;
      end
    end

    // led acts on the resulting mode, ticks only
    if (!s1_mode_r) begin
      unique case (mode_nxt)
        urlc_pkg::LED_FLASH: begin
          flash_cnt_nxt = urlc_pkg::sat_inc(flash_cnt_nxt);
          if (flash_cnt_nxt >= flash_ticks_r) begin
            led_nxt       = !led_nxt;
            flash_cnt_nxt = '0;
          end
        end
        urlc_pkg::LED_ON: led_nxt = 1'b1;
        default:          led_nxt = 1'b0;
      endcase
    end

    res.trigger_level = trig;
    res.led_level     = led_nxt;
    res.led_mode_now  = mode_nxt;
    res.range_cm      = last_dist_nxt;
    res.distance_new  = fin;
    res.timed_out     = tmo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= urlc_pkg::PH_GAP;
      cnt_r       <= '0;
      echo_q_r    <= '0;
      echo_rem_r  <= '0;
      mode_r      <= urlc_pkg::LED_FLASH;
      led_r       <= 1'b1;
      flash_cnt_r <= '0;
      last_dist_r <= '0;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      echo_q_r    <= echo_q_nxt;
      echo_rem_r  <= echo_rem_nxt;
      mode_r      <= mode_nxt;
      led_r       <= led_nxt;
      flash_cnt_r <= flash_cnt_nxt;
      last_dist_r <= last_dist_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result ports
  // ---------------------------------------------------------------------------
  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_r.trigger_level;
  assign out_led_level     = out_r.led_level;
  assign out_led_mode_now  = out_r.led_mode_now;
  assign out_range_cm      = out_r.range_cm;
  assign out_distance_new  = out_r.distance_new;
  assign out_timed_out     = out_r.timed_out;

endmodule

// ===== src/urlc_checker.sv =====
// port-level checks for the ultrasonic ranging led controller, with bind
module urlc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_trigger_level,
  input logic                               out_led_level,
  input logic [1:0]                         out_led_mode_now,
  input logic [urlc_pkg::DIST_W-1:0]        out_range_cm,
  input logic                               out_distance_new,
  input logic                               out_timed_out
);

  // stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_cm)
      && $stable(out_led_level) && $stable(out_led_mode_now))
    else $error("result changed while stalled");

  // a timeout always finishes a measurement with distance zero
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_distance_new && out_range_cm == '0)
    else $error("timeout without zero finished distance");

  // steady modes drive the led to their own level
  a_led_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_led_mode_now == urlc_pkg::LED_ON
                  || out_led_mode_now == urlc_pkg::LED_OFF)
      |-> out_led_level == (out_led_mode_now == urlc_pkg::LED_ON))
    else $error("led level disagrees with steady mode");

  // the trigger pulse and a finished measurement never share an item
  a_trig_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_level |-> !out_distance_new)
    else $error("trigger high on a finished measurement");

endmodule

bind ultrasonic_ranging_led_controller urlc_checker u_urlc_checker (.*);

// ===== verif/ultrasonic_ranging_led_controller_test.sv =====
// self-checking testbench for the ultrasonic ranging led controller
module ultrasonic_ranging_led_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  // run ends as a failure past this many clocks
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic                           in_valid = 1'b0;
  logic                           in_mode = 1'b0;
  logic                           in_echo_level = 1'b0;
  logic [7:0]                     in_command_byte = 8'h00;
  logic                           out_ready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [urlc_pkg::CFG_IDX_W-1:0] cfg_index = urlc_pkg::CFG_TRIGGER_TICKS;
  logic [urlc_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // block outputs
  logic                        in_ready;
  logic                        out_valid;
  logic                        out_trigger_level;
  logic                        out_led_level;
  logic [1:0]                  out_led_mode_now;
  logic [urlc_pkg::DIST_W-1:0] out_range_cm;
  logic                        out_distance_new;
  logic                        out_timed_out;

  ultrasonic_ranging_led_controller uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_echo_level     (in_echo_level),
    .in_command_byte   (in_command_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_led_level     (out_led_level),
    .out_led_mode_now  (out_led_mode_now),
    .out_range_cm      (out_range_cm),
    .out_distance_new  (out_distance_new),
    .out_timed_out     (out_timed_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // ranging model: own copy of the settings and of the measurement state
  // ---------------------------------------------------------------------------
  logic [urlc_pkg::TRIG_W-1:0] trig_lim    = urlc_pkg::RST_TRIGGER_TICKS;
  logic [urlc_pkg::TICK_W-1:0] timeout_lim = urlc_pkg::RST_TIMEOUT_TICKS;
  logic [urlc_pkg::DIST_W-1:0] near_lim    = urlc_pkg::RST_NEAR_CM;
  logic [urlc_pkg::DIST_W-1:0] far_lim     = urlc_pkg::RST_FAR_CM;
  logic [urlc_pkg::TICK_W-1:0] flash_lim   = urlc_pkg::RST_FLASH_TICKS;
  logic [urlc_pkg::TICK_W-1:0] gap_lim     = urlc_pkg::RST_GAP_TICKS;

  urlc_pkg::phase_t            ph          = urlc_pkg::PH_GAP;
  logic [urlc_pkg::TICK_W-1:0] ph_count    = '0;
  logic [urlc_pkg::TICK_W-1:0] pulse_width = '0;
  urlc_pkg::led_mode_t         led_mode    = urlc_pkg::LED_FLASH;
  logic                        led         = 1'b1;
  logic [urlc_pkg::TICK_W-1:0] flash_count = '0;
  logic [urlc_pkg::DIST_W-1:0] last_dist   = '0;

  // readings predicted for accepted transactions, oldest first
  urlc_pkg::res_t expected_readings[$];
  int unsigned mismatches = 0;

  // idling controls: percent chance per item / per cycle, and the idle-free tail
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          quiet = 1'b0;

  // echo shaping for well-formed measurements
  int unsigned rise_plan = 0;
  int unsigned width_plan = 0;
  int unsigned rise_seen = 0;
  int unsigned high_seen = 0;

  // counters stick at all ones
  function automatic logic [urlc_pkg::TICK_W-1:0] bump(
      input logic [urlc_pkg::TICK_W-1:0] v);
    return (v == {urlc_pkg::TICK_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // switching into flashing restarts the toggle count; on/off set the pin at once
  task automatic change_mode(input urlc_pkg::led_mode_t m);
    if (m == urlc_pkg::LED_FLASH && led_mode != urlc_pkg::LED_FLASH) flash_count = '0;
    led_mode = m;
    if (m == urlc_pkg::LED_ON) led = 1'b1;
    else if (m == urlc_pkg::LED_OFF) led = 1'b0;
  endtask

  task automatic predict_reading(input logic mode, input logic echo, input logic [7:0] cmd,
                                 output urlc_pkg::res_t r);
    logic                        trig;
    logic                        fin;
    logic                        tmo;
    logic [urlc_pkg::DIST_W-1:0] meas_cm;
    int unsigned                 cm;
    trig    = 1'b0;
    fin     = 1'b0;
    tmo     = 1'b0;
    meas_cm = '0;
    if (!mode) begin
      // phase machine: an ending gap or trigger phase hands the same tick to the next one
      if (ph == urlc_pkg::PH_GAP) begin
        if (ph_count < gap_lim) begin
          ph_count = bump(ph_count);
        end else begin
          ph = urlc_pkg::PH_TRIG;
          ph_count = '0;
        end
      end
      if (ph == urlc_pkg::PH_TRIG) begin
        if (ph_count < urlc_pkg::TICK_W'(trig_lim)) begin
          trig = 1'b1;
          ph_count = bump(ph_count);
        end else begin
          ph = urlc_pkg::PH_RISE;
          ph_count = '0;
        end
      end
      if (ph == urlc_pkg::PH_RISE) begin
        if (echo) begin
          ph = urlc_pkg::PH_FALL;
          ph_count = '0;
          pulse_width = urlc_pkg::TICK_W'(1);
        end else if (ph_count >= timeout_lim) begin
          fin = 1'b1;
          tmo = 1'b1;
        end else begin
          ph_count = bump(ph_count);
        end
      end else if (ph == urlc_pkg::PH_FALL) begin
        if (!echo) begin
          cm = pulse_width / urlc_pkg::US_PER_CM;
          meas_cm = (cm > urlc_pkg::DIST_MAX) ? urlc_pkg::DIST_MAX : urlc_pkg::DIST_W'(cm);
          fin = 1'b1;
        end else if (ph_count >= timeout_lim) begin
          fin = 1'b1;
          tmo = 1'b1;
        end else begin
          ph_count = bump(ph_count);
          pulse_width = bump(pulse_width);
        end
      end
      // finished measurement picks the led mode from the distance
      if (fin) begin
        last_dist = meas_cm;
        ph = urlc_pkg::PH_GAP;
        ph_count = '0;
        if (meas_cm < near_lim) change_mode(urlc_pkg::LED_ON);
        else if (meas_cm < far_lim) change_mode(urlc_pkg::LED_FLASH);
        else change_mode(urlc_pkg::LED_OFF);
      end
      // led acts on the mode after the phase machine
      case (led_mode)
        urlc_pkg::LED_FLASH: begin
          flash_count = bump(flash_count);
          if (flash_count >= flash_lim) begin
            led = ~led;
            flash_count = '0;
          end
        end
        urlc_pkg::LED_ON: led = 1'b1;
        default: led = 1'b0;
      endcase
    end else begin
      // command: phases hold, trigger shows the held level
      trig = (ph == urlc_pkg::PH_TRIG);
      case (cmd)
        urlc_pkg::CMD_ON_UC, urlc_pkg::CMD_ON_LC:       change_mode(urlc_pkg::LED_ON);
        urlc_pkg::CMD_OFF_UC, urlc_pkg::CMD_OFF_LC:     change_mode(urlc_pkg::LED_OFF);
        urlc_pkg::CMD_FLASH_UC, urlc_pkg::CMD_FLASH_LC: change_mode(urlc_pkg::LED_FLASH);
        default: ;
      endcase
    end
    r.trigger_level = trig;
    r.led_level     = led;
    r.led_mode_now  = led_mode;
    r.range_cm      = last_dist;
    r.distance_new  = fin;
    r.timed_out     = tmo;
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transaction; valid stays high afterwards unless a gap follows
  task automatic send_item(input logic mode, input logic echo, input logic [7:0] cmd);
    urlc_pkg::res_t r;
    int unsigned    pause;
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      pause = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_echo_level   <= echo;
    in_command_byte <= cmd;
    do @(posedge clk); while (!in_ready);
    predict_reading(mode, echo, cmd, r);
    expected_readings.push_back(r);
  endtask

  task automatic send_tick(input logic echo);
    send_item(1'b0, echo, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_cmd(input logic [7:0] cmd);
    send_item(1'b1, 1'($urandom_range(0, 1)), cmd);
  endtask

  // stop sending and let every predicted reading come back, then a short settle
  task automatic wait_all_readings();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all six registers, back to back; only called with the block drained
  task automatic load_settings(input logic [urlc_pkg::TRIG_W-1:0] t,
                               input logic [urlc_pkg::TICK_W-1:0] tmo,
                               input logic [urlc_pkg::DIST_W-1:0] nr,
                               input logic [urlc_pkg::DIST_W-1:0] fr,
                               input logic [urlc_pkg::TICK_W-1:0] fl,
                               input logic [urlc_pkg::TICK_W-1:0] gp);
    cfg_we    <= 1'b1;
    cfg_index <= urlc_pkg::CFG_TRIGGER_TICKS;
    cfg_wdata <= urlc_pkg::CFG_W'(t);
    @(posedge clk);
    cfg_index <= urlc_pkg::CFG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= urlc_pkg::CFG_NEAR_CM;
    cfg_wdata <= urlc_pkg::CFG_W'(nr);
    @(posedge clk);
    cfg_index <= urlc_pkg::CFG_FAR_CM;
    cfg_wdata <= urlc_pkg::CFG_W'(fr);
    @(posedge clk);
    cfg_index <= urlc_pkg::CFG_FLASH_TICKS;
    cfg_wdata <= fl;
    @(posedge clk);
    cfg_index <= urlc_pkg::CFG_GAP_TICKS;
    cfg_wdata <= gp;
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_lim    = t;
    timeout_lim = tmo;
    near_lim    = nr;
    far_lim     = fr;
    flash_lim   = fl;
    gap_lim     = gp;
  endtask

  // shape of the next echo: delay before rise and high length, sometimes past the limit
  task automatic plan_echo();
    rise_seen = 0;
    high_seen = 0;
    if ($urandom_range(0, 5) == 0) rise_plan = timeout_lim + 1;
    else rise_plan = $urandom_range(0, 8);
    if ($urandom_range(0, 5) == 0) width_plan = timeout_lim + 2;
    else if ($urandom_range(0, 1) == 0) width_plan = $urandom_range(0, 70);
    else width_plan = $urandom_range(100, 240);
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 9))
      0: return urlc_pkg::CMD_ON_UC;
      1: return urlc_pkg::CMD_ON_LC;
      2: return urlc_pkg::CMD_OFF_UC;
      3: return urlc_pkg::CMD_OFF_LC;
      4: return urlc_pkg::CMD_FLASH_UC;
      5: return urlc_pkg::CMD_FLASH_LC;
      6: return urlc_pkg::CMD_FLASH_LC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly echo that follows the planned measurement, some commands, optional noise
  task automatic send_random_item(input bit noisy);
    logic echo;
    if ($urandom_range(0, 9) == 0) begin
      send_cmd(pick_command());
    end else begin
      case (ph)
        urlc_pkg::PH_RISE: begin
          echo = (rise_seen >= rise_plan);
          rise_seen++;
        end
        urlc_pkg::PH_FALL: begin
          echo = (high_seen < width_plan);
          high_seen++;
        end
        default: echo = ($urandom_range(0, 15) == 0);
      endcase
      if (noisy) echo = 1'($urandom_range(0, 1));
      send_tick(echo);
      if (expected_readings[$].distance_new) plan_echo();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready drops in random bursts of cycles
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic string reading_str(input urlc_pkg::res_t r);
    return $sformatf("trig=%0b led=%0b mode=%0d range=%0d new=%0b tmo=%0b",
                     r.trigger_level, r.led_level, r.led_mode_now, r.range_cm,
                     r.distance_new, r.timed_out);
  endfunction

  always @(posedge clk) begin
    urlc_pkg::res_t got;
    urlc_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.trigger_level = out_trigger_level;
      got.led_level     = out_led_level;
      got.led_mode_now  = urlc_pkg::led_mode_t'(out_led_mode_now);
      got.range_cm      = out_range_cm;
      got.distance_new  = out_distance_new;
      got.timed_out     = out_timed_out;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", reading_str(got));
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s, got %s", reading_str(want), reading_str(got));
        end
      end
    end
  end

  // watchdog
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ultrasonic_ranging_led_controller] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default settings right after reset: every command, unknown bytes, a few ticks
  task automatic test_reset_defaults();
    idle_pct  = 30;
    stall_pct = 10;
    send_tick(1'b0);
    send_cmd(urlc_pkg::CMD_OFF_UC);
    send_tick(1'b1);
    send_cmd(urlc_pkg::CMD_ON_LC);
    send_cmd(urlc_pkg::CMD_FLASH_UC);
    send_cmd(8'hFF);
    send_cmd(urlc_pkg::CMD_OFF_LC);
    send_cmd(urlc_pkg::CMD_ON_UC);
    send_cmd(8'h00);
    send_cmd(urlc_pkg::CMD_FLASH_LC);
    wait_all_readings();
  endtask

  // short measurement, rise timeout, command held in trigger, zero and top settings
  task automatic test_measure_directed();
    load_settings(urlc_pkg::TRIG_W'(1), urlc_pkg::TICK_W'(3), urlc_pkg::DIST_W'(1),
                  urlc_pkg::DIST_W'(2), urlc_pkg::TICK_W'(1), urlc_pkg::TICK_W'(0));
    send_tick(1'b0);                    // gap ends at once, trigger goes high
    send_cmd(urlc_pkg::CMD_FLASH_LC);   // trigger level held during the command
    send_tick(1'b0);
    send_tick(1'b1);                    // echo rises
    send_tick(1'b1);
    send_tick(1'b0);                    // echo falls, distance zero, led on
    repeat (6) send_tick(1'b0);         // rise wait runs out
    send_cmd(urlc_pkg::CMD_OFF_UC);
    send_tick(1'b0);
    wait_all_readings();
    // zero trigger, zero timeout, toggle every tick, no gap
    load_settings('0, '0, '0, urlc_pkg::DIST_MAX, '0, '0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_all_readings();
    // widest trigger, limit, flash and gap values
    load_settings({urlc_pkg::TRIG_W{1'b1}}, urlc_pkg::TICK_MAX, urlc_pkg::DIST_MAX, '0,
                  urlc_pkg::TICK_MAX, urlc_pkg::TICK_MAX);
    send_tick(1'b1);
    send_cmd(urlc_pkg::CMD_FLASH_UC);
    send_tick(1'b0);
    wait_all_readings();
  endtask

  // random settings per phase, well-formed measurements with random content, noisy echo in some phases
  task automatic test_random_phases();
    logic [urlc_pkg::TRIG_W-1:0] t;
    logic [urlc_pkg::TICK_W-1:0] tmo;
    logic [urlc_pkg::DIST_W-1:0] nr;
    logic [urlc_pkg::DIST_W-1:0] fr;
    logic [urlc_pkg::TICK_W-1:0] fl;
    logic [urlc_pkg::TICK_W-1:0] gp;
    for (int p = 0; p < 14; p++) begin
      wait_all_readings();
      t   = urlc_pkg::TRIG_W'($urandom_range(0, 20));
      tmo = urlc_pkg::TICK_W'($urandom_range(0, 300));
      nr  = urlc_pkg::DIST_W'($urandom_range(0, 4));
      fr  = urlc_pkg::DIST_W'($urandom_range(0, 6));
      fl  = urlc_pkg::TICK_W'($urandom_range(0, 16));
      gp  = urlc_pkg::TICK_W'($urandom_range(0, 24));
      case (p)
        1: begin            // nothing is near or mid range: measurements turn the led off
          nr = '0;
          fr = '0;
        end
        2: begin            // everything counts as near
          nr = urlc_pkg::DIST_MAX;
          fr = urlc_pkg::DIST_MAX;
        end
        3: t = {urlc_pkg::TRIG_W{1'b1}};
        4: begin
          fl = urlc_pkg::TICK_MAX;
          gp = '0;
        end
        default: ;
      endcase
      load_settings(t, tmo, nr, fr, fl, gp);
      plan_echo();
      // some phases run without any idling
      idle_pct  = (p % 4 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(3, 20);
      for (int k = 0; k < 114; k++) begin
        // sender holds off once until the block has caught up
        if (p == 6 && k == 60) wait_all_readings();
        send_random_item(p % 5 == 4);
      end
    end
    wait_all_readings();
  endtask

  // last stretch with neither side idling
  task automatic test_quiet_tail();
    quiet = 1'b1;
    load_settings(urlc_pkg::TRIG_W'(3), urlc_pkg::TICK_W'(150), urlc_pkg::DIST_W'(2),
                  urlc_pkg::DIST_W'(3), urlc_pkg::TICK_W'(5), urlc_pkg::TICK_W'(4));
    plan_echo();
    repeat (120) send_random_item(1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_measure_directed();
    test_random_phases();
    test_quiet_tail();
    wait_all_readings();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("[ultrasonic_ranging_led_controller] OK");
    end else begin
      $display("[ultrasonic_ranging_led_controller] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/urlc_pkg.sv
src/ultrasonic_ranging_led_controller.sv
src/urlc_checker.sv
verif/ultrasonic_ranging_led_controller_test.sv
